// ----- hw/rtl/nus_pkg.sv -----
// ----------------------------------------------------------------------------
// nus_pkg
// Shared types and constants for the byte stream unit splitter.
// ----------------------------------------------------------------------------
package nus_pkg;

   // Window geometry
   localparam int WIN_LEN       = 4;
   localparam int WIN_IDX_W     = $clog2(WIN_LEN);
   localparam int FILL_W        = $clog2(WIN_LEN + 1);

   // Unit length field and its saturation limit
   localparam int LEN_W          = 17;
   localparam int LEN_FIELD_MAX  = (1 << LEN_W) - 1;
   localparam int MAX_UNIT_BYTES = 65536;
   localparam int LEN_LIMIT_INT  =
      (MAX_UNIT_BYTES < LEN_FIELD_MAX) ? MAX_UNIT_BYTES : LEN_FIELD_MAX;
   localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(LEN_LIMIT_INT);

   // Start code pattern bytes
   localparam logic [7:0] SC_ZERO = 8'h00;
   localparam logic [7:0] SC_ONE  = 8'h01;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       end_of_stream;
   } req_type;

   typedef struct packed {
      logic [7:0]       out_byte;
      logic             unit_first;
      logic             unit_last;
      logic [LEN_W-1:0] unit_length;
      logic             run_end;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_RUN   = 2'b01,
      ST_FLUSH = 2'b10
   } state_type;

   // Saturating unit length increment
   function automatic logic [LEN_W-1:0] count_up(input logic [LEN_W-1:0] c);
      count_up = (c < LEN_LIMIT) ? c + LEN_W'(1) : LEN_LIMIT;
   endfunction

endpackage

// ----- hw/rtl/nus_cell.sv -----
// ----------------------------------------------------------------------------
// nus_cell
// One byte cell of the pending window; takes its neighbor's byte on shift.
// ----------------------------------------------------------------------------
module nus_cell import nus_pkg::*; (
   input  logic       clock,
   input  logic       shift_en,
   input  logic [7:0] d_in,
   output logic [7:0] q,
   output logic       is_zero
);

   logic [7:0] byte_ff;
   logic [7:0] byte_in;

   // Take the neighbor's byte when the chain advances
   always_comb begin
      byte_in = shift_en ? d_in : byte_ff;
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
   end

   assign q       = byte_ff;
   assign is_zero = (byte_ff == SC_ZERO);

endmodule

// ----- hw/rtl/nal_unit_splitter.sv -----
// ----------------------------------------------------------------------------
// nal_unit_splitter
// Splits a byte stream into units at each 00 00 00 01 start code.
// ----------------------------------------------------------------------------
// Usage:
//   The req channel takes one stream word per cycle while req_ready is
//   high: a byte plus an end-of-stream flag. The rsp channel returns the
//   bytes of each unit, start code included, with first and last marks;
//   the last word of a unit carries its length, saturating at
//   MAX_UNIT_BYTES. Bytes before the first start code are dropped.
//   A byte is held in a four-cell window until the following bytes show
//   whether a start code begins. Throughput is one word per cycle while
//   the receiver keeps up and no flush runs, set by the single output
//   register and the window shift.
//   An end-of-stream word inside a unit flushes the four pending bytes;
//   req_ready is low during the flush. The block then returns to its
//   reset state and the next word starts a new stream.
//   A stalled receiver holds the output register; req_ready drops until
//   the held word is taken. Reset clears all control state and empties
//   the output register.
// ----------------------------------------------------------------------------
module nal_unit_splitter import nus_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   // Window cells
   logic [7:0]         win_q   [WIN_LEN];
   logic [7:0]         win_d   [WIN_LEN];
   logic [WIN_LEN-1:0] win_zero;
   logic               shift_en;

   // Control state
   state_type          state_ff, state_in;
   logic [FILL_W-1:0]  fill_ff, fill_in;
   logic               in_unit_ff, in_unit_in;
   logic               head_first_ff, head_first_in;
   logic [LEN_W-1:0]   count_ff, count_in;
   logic [WIN_IDX_W-1:0] flush_idx_ff, flush_idx_in;

   // Output register
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   logic               slot_free;
   logic               accept;
   logic               flush_step;
   logic               full;
   logic               new_full;
   logic               sc_new;
   logic [LEN_W-1:0]   count_next;

   // Build the chain: cell i takes from cell i+1, the top cell takes the input
   for (genvar i = 0; i < WIN_LEN; i++) begin : g_cell
      if (i == WIN_LEN - 1) begin : g_top
         assign win_d[i] = req_data.in_byte;
      end else begin : g_mid
         assign win_d[i] = win_q[i+1];
      end
      nus_cell u_cell (
         .clock    (clock),
         .shift_en (shift_en),
         .d_in     (win_d[i]),
         .q        (win_q[i]),
         .is_zero  (win_zero[i])
      );
   end

   assign slot_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready  = (state_ff == ST_RUN) && slot_free;
   assign accept     = req_valid && req_ready;
   assign flush_step = (state_ff == ST_FLUSH) && slot_free;
   assign shift_en   = accept || flush_step;

   assign full       = (fill_ff == FILL_W'(WIN_LEN));
   assign new_full   = full || (fill_ff == FILL_W'(WIN_LEN - 1));
   // Start code check on the window as it stands after the shift
   assign sc_new     = win_zero[1] && win_zero[2] && win_zero[3] &&
                       (req_data.in_byte == SC_ONE);
   assign count_next = count_up(count_ff);

   // Advance window control, emit words, run the end-of-stream flush
   always_comb begin
      state_in      = state_ff;
      fill_in       = fill_ff;
      in_unit_in    = in_unit_ff;
      head_first_in = head_first_ff;
      count_in      = count_ff;
      flush_idx_in  = flush_idx_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_data_in   = rsp_data_ff;

      unique case (state_ff)
         ST_RUN: begin
            if (accept) begin
               fill_in = full ? fill_ff : fill_ff + FILL_W'(1);
               if (full && in_unit_ff) begin
                  rsp_valid_in            = 1'b1;
                  rsp_data_in.out_byte    = win_q[0];
                  rsp_data_in.unit_first  = head_first_ff;
                  rsp_data_in.unit_last   = sc_new;
                  rsp_data_in.unit_length = sc_new ? count_next : '0;
                  rsp_data_in.run_end     = !req_data.end_of_stream;
                  head_first_in           = sc_new;
                  count_in                = sc_new ? '0 : count_next;
               end else if (new_full && !in_unit_ff && sc_new) begin
                  in_unit_in    = 1'b1;
                  head_first_in = 1'b1;
                  count_in      = '0;
               end
               // Flush pending bytes inside a unit, otherwise drop them
               if (req_data.end_of_stream) begin
                  if (in_unit_in) begin
                     state_in     = ST_FLUSH;
                     flush_idx_in = '0;
                  end else begin
                     fill_in       = '0;
                     in_unit_in    = 1'b0;
                     head_first_in = 1'b0;
                     count_in      = '0;
                  end
               end
            end
         end
         ST_FLUSH: begin
            if (flush_step) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.out_byte    = win_q[0];
               rsp_data_in.unit_first  = head_first_ff;
               rsp_data_in.unit_last   = (flush_idx_ff == WIN_IDX_W'(WIN_LEN - 1));
               rsp_data_in.unit_length =
                  (flush_idx_ff == WIN_IDX_W'(WIN_LEN - 1)) ? count_next : '0;
               rsp_data_in.run_end     = (flush_idx_ff == WIN_IDX_W'(WIN_LEN - 1));
               head_first_in           = 1'b0;
               count_in                = count_next;
               flush_idx_in            = flush_idx_ff + WIN_IDX_W'(1);
               if (flush_idx_ff == WIN_IDX_W'(WIN_LEN - 1)) begin
                  state_in      = ST_RUN;
                  fill_in       = '0;
                  in_unit_in    = 1'b0;
                  head_first_in = 1'b0;
                  count_in      = '0;
               end
            end
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase
   end

   // Hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_RUN;
         fill_ff       <= '0;
         in_unit_ff    <= 1'b0;
         head_first_ff <= 1'b0;
         count_ff      <= '0;
         flush_idx_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         fill_ff       <= fill_in;
         in_unit_ff    <= in_unit_in;
         head_first_ff <= head_first_in;
         count_ff      <= count_in;
         flush_idx_ff  <= flush_idx_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Hold the output word
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
